>>> rtl/run_queue_with_next_slot_core_macros.svh
// Assertion macros for the run queue core.
// Used by files that assert; they expect clk and rst_n in scope.
`ifndef RUN_QUEUE_WITH_NEXT_SLOT_CORE_MACROS_SVH
`define RUN_QUEUE_WITH_NEXT_SLOT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RQNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RQNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rqns_pkg.sv
// Shared types and codes for the run queue core.
// No dependencies.
package rqns_pkg;

  localparam int TASK_W = 16;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef logic [TASK_W-1:0] task_t;

  typedef struct packed {
    logic  kind;
    task_t task_id;
    logic  to_front;
  } in_item_t;

  typedef struct packed {
    logic  task_valid;
    task_t out_task;
    logic  inherit_time;
    logic  overflow;
  } out_item_t;

endpackage

>>> rtl/rqns_ring_ram.sv
// Ring storage: one write port, one read port, registered read data.
// Depends on rqns_pkg for the task type.
module rqns_ring_ram
  import rqns_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  task_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output task_t         rd_data
);

  task_t mem_r [DEPTH];
  task_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/rqns_ring_ptr.sv
// Ring pointer: index modulo the depth plus a phase bit that flips on wrap.
// No package dependency.
module rqns_ring_ptr #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          inc,
  output logic [AW-1:0] idx,
  output logic          phase
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] idx_r, idx_nxt;
  logic          phase_r, phase_nxt;

  always_comb begin
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    if (inc) begin
      if (idx_r == LAST) begin
        idx_nxt   = '0;
        phase_nxt = ~phase_r;
      end else begin
        idx_nxt = idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign idx   = idx_r;
  assign phase = phase_r;

endmodule

>>> rtl/run_queue_with_next_slot_core.sv
// Run queue core: a ring FIFO of task handles plus one priority next slot.
// Depends on rqns_pkg, rqns_ring_ptr, rqns_ring_ram and the assertion macros.
//
// Usage:
//   in_*  : one transfer per operation. kind selects put or get; on a put,
//           to_front places the task in the next slot and pushes any task
//           already there to the ring tail.
//   out_* : exactly one result transfer per operation, in operation order.
//           A get returns the next-slot task first (inherit_time set), else
//           the oldest ring entry, else task_valid low. A put that meets a
//           full ring hands the refused task back with overflow set.
// Result path:
//   Puts, next-slot gets and empty gets: the result is registered directly
//   from the input transfer; one operation per cycle is sustained while out_ready drains it.
//   Gets served from the ring: the ring memory registers the read data,
//   which then loads the output register; in_ready drops while that read is pending.
// Reset: rst_n (synchronous) empties the next slot and the ring. Ring
//   memory is not cleared; entries are only read after being written.
// Stall: a held result keeps out_data steady; a new operation is taken only
//   in a cycle the output register is empty or being drained and no ring read is pending.
module run_queue_with_next_slot_core
  import rqns_pkg::*;
#(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "run_queue_with_next_slot_core_macros.svh"

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Next slot
  logic  next_valid_r, next_valid_nxt;
  task_t next_task_r, next_task_nxt;

  // Output register and pending ring read
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      pend_r;

  // Ring pointers and memory
  logic [AW-1:0] head_idx, tail_idx;
  logic          head_ph, tail_ph;
  logic          ring_empty, ring_full;
  logic          wr_en, rd_en;
  task_t         push_task, rd_data;
  logic          need_push;

  logic      acc;
  out_item_t res;

  assign in_ready = !pend_r && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  // Equal indices: phases equal means empty, phases differ means full.
  assign ring_empty = (head_idx == tail_idx) && (head_ph == tail_ph);
  assign ring_full  = (head_idx == tail_idx) && (head_ph != tail_ph);

  rqns_ring_ptr #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_head (
    .clk   (clk),
    .rst_n (rst_n),
    .inc   (rd_en),
    .idx   (head_idx),
    .phase (head_ph)
  );

  rqns_ring_ptr #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_tail (
    .clk   (clk),
    .rst_n (rst_n),
    .inc   (wr_en),
    .idx   (tail_idx),
    .phase (tail_ph)
  );

  rqns_ring_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_idx),
    .wr_data (push_task),
    .rd_en   (rd_en),
    .rd_addr (head_idx),
    .rd_data (rd_data)
  );

  // Decode the accepted operation against the next slot and ring state.
  always_comb begin
    next_valid_nxt = next_valid_r;
    next_task_nxt  = next_task_r;
    push_task      = in_data.task_id;
    need_push      = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    res            = '0;
    if (acc) begin
      if (in_data.kind == KIND_PUT) begin
        if (in_data.to_front) begin
          // Displace the current next task, if any, towards the ring tail.
          need_push      = next_valid_r;
          push_task      = next_task_r;
          next_task_nxt  = in_data.task_id;
          next_valid_nxt = 1'b1;
        end else begin
          need_push = 1'b1;
        end
        if (need_push) begin
          if (ring_full) begin
            // Hand the task back; leave the ring untouched.
            res.task_valid = 1'b1;
            res.out_task   = push_task;
            res.overflow   = 1'b1;
          end else begin
            wr_en = 1'b1;
          end
        end
      end else begin
        if (next_valid_r) begin
          res.task_valid   = 1'b1;
          res.out_task     = next_task_r;
          res.inherit_time = 1'b1;
          next_valid_nxt   = 1'b0;
          next_task_nxt    = '0;
        end else if (!ring_empty) begin
          // Read the oldest entry; the read data is registered in the ring memory.
          rd_en = 1'b1;
        end
      end
    end
  end

  // Load the output register from the decode or from the ring read.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (acc && !rd_en) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (pend_r) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt              = '0;
      out_data_nxt.task_valid   = 1'b1;
      out_data_nxt.out_task     = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_valid_r <= 1'b0;
      next_task_r  <= '0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      next_valid_r <= next_valid_nxt;
      next_task_r  <= next_task_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= rd_en;
    end
  end

  // Hold payload without reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RQNS_ASSERT_NOW(a_pend_out_free, pend_r, !out_valid_r, "ring read landed on a full output register")
  `RQNS_ASSERT_NEXT(a_read_pends, rd_en, pend_r, "ring read not followed by pending state")
  `RQNS_ASSERT_NEXT(a_pend_loads, pend_r, out_valid_r && out_data_r.task_valid, "pending ring read produced no result")
  `RQNS_ASSERT_NEXT(a_ovf_no_write, acc && res.overflow, $stable(tail_idx) && $stable(tail_ph), "overflowing put moved the tail")
  `RQNS_ASSERT_NOW(a_no_read_empty, rd_en, !ring_empty && !next_valid_r, "ring read issued while empty or next slot held")

endmodule
